/* rtl/vst_pkg.sv */
// Shared types and constants for the voice segment tracker.
`default_nettype none

package vst_pkg;

  localparam int unsigned DIV_W     = 32;
  localparam int unsigned LEVEL_W   = 10;
  localparam int unsigned PROD_W    = 26;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 16;

  // The full scale 32767 is 2^SCALE_SH - 1.
  localparam int unsigned SCALE_SH  = 15;

  localparam logic [PROD_W-1:0] LEVEL_SCALE = PROD_W'(1000);
  localparam logic [15:0]       DUR_MAX     = 16'hFFFF;
  localparam logic [7:0]        BURST_MAX   = 8'hFF;

  localparam logic [CFG_IDX_W-1:0] CFG_BURST_GAP = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ACT_INT   = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    EV_START = 2'd0,
    EV_END   = 2'd1,
    EV_ACT   = 2'd2
  } event_kind_e;

  typedef enum logic [1:0] {
    DIV_MEAN,
    DIV_AVG
  } div_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MEAN_GO,
    ST_MEAN_WAIT,
    ST_LEVEL,
    ST_DECIDE,
    ST_AVG_GO,
    ST_AVG_WAIT,
    ST_END
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     acc;
    logic     clr_frame;
    logic     div_start;
    div_sel_e div_sel;
    logic     cap_prod;
    logic     cap_level;
    logic     decide;
    logic     end_seg;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;
    logic div_busy;
    logic is_end;
    logic out_free;
    logic in_seg;
  } sts_t;

endpackage

`default_nettype wire

/* rtl/voice_segment_tracker.sv */
// Top level of the voice segment tracker: controller, datapath and checks.
`default_nettype none

// Samples stream in on the slave side; a sample without tlast is taken and the
// block stays ready for the next one. A sample with tlast closes the frame: the
// mean goes through a shared 32-step divider and is then scaled to the level by
// a multiply and a reciprocal step, and no new sample is taken until the frame
// is decided; when a segment ends, its average level is divided out as well.
// Events leave through a one-entry result register on the master side; a frame
// end only waits on that register while an earlier event is still untaken. No
// clearing pass follows reset.
module voice_segment_tracker #(
  parameter int unsigned MAX_FRAME_SAMPLES = 1024
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  wire logic [47:0]                   s_axis_tdata_i,  // sample[15:0], now_ms[47:16]
  input  wire logic                          s_axis_tlast_i,  // frame_last
  input  wire logic                          s_axis_tuser_i,  // vad_active
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  // level_value[9:0], duration_ms[25:10], peak_level[35:26], burst_count[43:36]
  output logic [47:0]                        m_axis_tdata_o,
  output logic [1:0]                         m_axis_tuser_o,  // event_kind
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [vst_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [vst_pkg::CFG_W-1:0]     cfg_data_i
);
  import vst_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  vst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_last_i  (s_axis_tlast_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  vst_dp #(
    .MAX_FRAME_SAMPLES (MAX_FRAME_SAMPLES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (s_axis_tdata_i),
    .in_vad_i    (s_axis_tuser_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_data_o  (m_axis_tdata_o),
    .out_kind_o  (m_axis_tuser_o)
  );

  // A pending event is never overwritten by a new one.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.decide || cmd.end_seg) |-> sts.out_free)
    else $error("result register overwritten while an event is pending");

  // While an end event is shown, the segment is closed.
  a_end_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tuser_o == EV_END)) |-> !sts.in_seg)
    else $error("end event shown while a segment is still open");

  // Levels never exceed full scale.
  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[9:0] <= 10'd1000))
    else $error("level above full scale");

  // New samples are only taken while the divider is idle.
  a_idle_when_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !sts.div_busy)
    else $error("input ready while a division is running");

endmodule

`default_nettype wire

/* rtl/vst_div.sv */
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none

module vst_div (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [vst_pkg::DIV_W-1:0] dividend_i,
  input  wire logic [vst_pkg::DIV_W-1:0] divisor_i,
  output logic                           busy_o,
  output logic                           done_o,
  output logic [vst_pkg::DIV_W-1:0]      quotient_o
);
  import vst_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIV_W);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_W:0]   rem_q, rem_d;
  logic [DIV_W-1:0] quo_q, quo_d;
  logic [DIV_W-1:0] dsr_q, dsr_d;
  logic [DIV_W:0]   rem_sh;
  logic             ge;

  assign rem_sh = {rem_q[DIV_W-1:0], quo_q[DIV_W-1]};
  assign ge     = rem_sh >= {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? (rem_sh - {1'b0, dsr_q}) : rem_sh;
      quo_d = {quo_q[DIV_W-2:0], ge};
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(DIV_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

/* rtl/vst_ctrl.sv */
// Sequencing state machine for the voice segment tracker.
`default_nettype none

module vst_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          in_last_i,
  output logic               in_ready_o,
  input  wire vst_pkg::sts_t sts_i,
  output vst_pkg::cmd_t      cmd_o
);
  import vst_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.div_sel = DIV_MEAN;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.acc = 1'b1;
          if (in_last_i) begin
            state_d = ST_MEAN_GO;
          end
        end
      end
      ST_MEAN_GO: begin
        // The divider takes the sum now, so the frame accumulators may clear.
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_MEAN;
        cmd_o.clr_frame = 1'b1;
        state_d         = ST_MEAN_WAIT;
      end
      ST_MEAN_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.cap_prod = 1'b1;
          state_d        = ST_LEVEL;
        end
      end
      ST_LEVEL: begin
        cmd_o.cap_level = 1'b1;
        state_d         = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (sts_i.is_end) begin
          state_d = ST_AVG_GO;
        end else if (sts_i.out_free) begin
          cmd_o.decide = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_AVG_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_AVG;
        state_d         = ST_AVG_WAIT;
      end
      ST_AVG_WAIT: begin
        if (sts_i.div_done) begin
          state_d = ST_END;
        end
      end
      ST_END: begin
        if (sts_i.out_free) begin
          cmd_o.end_seg = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/vst_dp.sv */
// Datapath: frame accumulation, level arithmetic, segment state and result register.
`default_nettype none

module vst_dp #(
  parameter int unsigned MAX_FRAME_SAMPLES = 1024
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire vst_pkg::cmd_t                 cmd_i,
  output vst_pkg::sts_t                      sts_o,
  input  wire logic [47:0]                   in_data_i,
  input  wire logic                          in_vad_i,
  input  wire logic                          cfg_valid_i,
  input  wire logic [vst_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [vst_pkg::CFG_W-1:0]     cfg_data_i,
  input  wire logic                          out_ready_i,
  output logic                               out_valid_o,
  output logic [47:0]                        out_data_o,
  output logic [1:0]                         out_kind_o
);
  import vst_pkg::*;

  localparam int unsigned SUM_W = $clog2(MAX_FRAME_SAMPLES * 32768 + 1);
  localparam int unsigned CNT_W = $clog2(MAX_FRAME_SAMPLES + 1);

  // Configuration registers.
  logic [CFG_W-1:0] gap_q, int_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q <= CFG_W'(1500);
      int_q <= CFG_W'(250);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_BURST_GAP: gap_q <= cfg_data_i;
        CFG_ACT_INT:   int_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Frame accumulation.
  logic signed [15:0] sample;
  logic [15:0]        mag;
  logic [SUM_W-1:0]   sum_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               vad_q;
  logic [31:0]        now_q;

  assign sample = in_data_i[15:0];
  assign mag    = sample[15] ? (16'd0 - sample) : sample;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      cnt_q <= '0;
    end else if (cmd_i.clr_frame) begin
      sum_q <= '0;
      cnt_q <= '0;
    end else if (cmd_i.acc && (cnt_q < CNT_W'(MAX_FRAME_SAMPLES))) begin
      sum_q <= sum_q + SUM_W'(mag);
      cnt_q <= cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc) begin
      vad_q <= in_vad_i;
      now_q <= in_data_i[47:16];
    end
  end

  // Shared divider and its operand selection.
  logic [DIV_W-1:0]   dvd, dsr, quo;
  logic               div_busy, div_done;
  logic [PROD_W-1:0]  prod_q;
  logic [PROD_W:0]    lvl_sum;
  logic [LEVEL_W-1:0] level_q;
  logic [31:0]        total_q, frames_q;

  always_comb begin
    case (cmd_i.div_sel)
      DIV_AVG: begin
        dvd = total_q;
        dsr = frames_q;
      end
      default: begin
        dvd = DIV_W'(sum_q);
        dsr = DIV_W'(cnt_q);
      end
    endcase
  end

  vst_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dvd),
    .divisor_i  (dsr),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  // Division by 2^15 - 1: for products below 2^30 - 1, (x + (x >> 15) + 1) >> 15
  // is the exact quotient.
  assign lvl_sum = {1'b0, prod_q} + (PROD_W+1)'(prod_q >> SCALE_SH) + (PROD_W+1)'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_prod) begin
      prod_q <= PROD_W'(quo[15:0]) * LEVEL_SCALE;
    end
    if (cmd_i.cap_level) begin
      level_q <= lvl_sum[SCALE_SH +: LEVEL_W];
    end
  end

  // Segment tracking.
  logic               in_seg_q;
  logic [31:0]        seg_start_q, last_end_q, last_act_q;
  logic [7:0]         bursts_q;
  logic [LEVEL_W-1:0] max_q;
  logic [31:0]        gap_diff, act_diff, dur_diff;
  logic [32:0]        tot_sum;
  logic               burst_cont, act_hit, tot_fits, is_start, is_cont;
  logic [15:0]        dur_sat;
  logic [LEVEL_W-1:0] avg;

  assign gap_diff   = now_q - last_end_q;
  assign act_diff   = now_q - last_act_q;
  assign dur_diff   = now_q - seg_start_q;
  assign burst_cont = (last_end_q != '0) && (gap_diff <= {16'd0, gap_q});
  assign act_hit    = act_diff >= {16'd0, int_q};
  assign tot_sum    = {1'b0, total_q} + 33'(level_q);
  assign tot_fits   = !tot_sum[32] && (frames_q != '1);
  assign is_start   = vad_q && !in_seg_q;
  assign is_cont    = vad_q && in_seg_q;
  assign dur_sat    = (dur_diff[31:16] != '0) ? DUR_MAX : dur_diff[15:0];
  assign avg        = (frames_q == '0) ? '0 : quo[LEVEL_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_seg_q    <= 1'b0;
      seg_start_q <= '0;
      last_end_q  <= '0;
      last_act_q  <= '0;
      bursts_q    <= '0;
      total_q     <= '0;
      frames_q    <= '0;
      max_q       <= '0;
    end else if (cmd_i.end_seg) begin
      in_seg_q   <= 1'b0;
      last_end_q <= now_q;
    end else if (cmd_i.decide) begin
      if (is_start) begin
        in_seg_q    <= 1'b1;
        seg_start_q <= now_q;
        last_act_q  <= now_q;
        total_q     <= 32'(level_q);
        frames_q    <= 32'd1;
        max_q       <= level_q;
        if (!burst_cont) begin
          bursts_q <= 8'd1;
        end else if (bursts_q != BURST_MAX) begin
          bursts_q <= bursts_q + 8'd1;
        end
      end else if (is_cont) begin
        if (tot_fits) begin
          total_q  <= tot_sum[31:0];
          frames_q <= frames_q + 32'd1;
        end
        if (level_q > max_q) begin
          max_q <= level_q;
        end
        if (act_hit) begin
          last_act_q <= now_q;
        end
      end
    end
  end

  // Result register; it takes a new result as soon as the old one is transferred.
  logic        out_valid_q;
  logic [47:0] out_data_q;
  logic [1:0]  out_kind_q;
  logic        out_free, load_start, load_act;

  assign out_free   = !out_valid_q || out_ready_i;
  assign load_start = cmd_i.decide && is_start;
  assign load_act   = cmd_i.decide && is_cont && act_hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_start || load_act || cmd_i.end_seg) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.end_seg) begin
      out_kind_q <= EV_END;
      out_data_q <= {4'd0, bursts_q, max_q, dur_sat, avg};
    end else if (load_start || load_act) begin
      out_kind_q <= load_start ? EV_START : EV_ACT;
      out_data_q <= {4'd0, 8'd0, {LEVEL_W{1'b0}}, 16'd0, level_q};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_kind_o  = out_kind_q;

  assign sts_o.div_done = div_done;
  assign sts_o.div_busy = div_busy;
  assign sts_o.is_end   = !vad_q && in_seg_q;
  assign sts_o.out_free = out_free;
  assign sts_o.in_seg   = in_seg_q;

endmodule

`default_nettype wire

/* test/tb_voice_segment_tracker.sv */
// Self-checking testbench for the voice segment tracker: sample stream in, segment events out.
module tb_voice_segment_tracker;
  import vst_pkg::*;

  localparam int unsigned FRAME_CAP      = 1024;
  localparam int unsigned LEVEL_FULL     = 1000;
  localparam int unsigned SAMPLE_FULL    = 32767;
  localparam int unsigned DRAIN_CYCLES   = 200;
  localparam int unsigned HOLD_CYCLES    = 3000;
  localparam int unsigned TIME_LIMIT     = 20_000_000;

  // Register slots that the block does not implement.
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_HI = CFG_IDX_W'(3);

  typedef struct packed {
    logic [15:0] sample;
    logic        last;
    logic        vad;
    logic [31:0] now_ms;
  } sample_item_t;

  typedef struct {
    event_kind_e kind;
    logic [9:0]  level;
    logic [15:0] dur;
    logic [9:0]  peak;
    logic [7:0]  bursts;
  } seg_event_t;

  logic                 clk_i           = 1'b0;
  logic                 rst_ni          = 1'b0;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  logic [47:0]          s_axis_tdata_i  = '0;  // sample[15:0], now_ms[47:16]
  logic                 s_axis_tlast_i  = 1'b0;  // frame_last
  logic                 s_axis_tuser_i  = 1'b0;  // vad_active
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  // level_value[9:0], duration_ms[25:10], peak_level[35:26], burst_count[43:36]
  logic [47:0]          m_axis_tdata_o;
  logic [1:0]           m_axis_tuser_o;  // event_kind
  logic                 cfg_valid_i     = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i     = '0;
  logic [CFG_W-1:0]     cfg_data_i      = '0;

  voice_segment_tracker u_dut (.*);

  always #4 clk_i = ~clk_i;

  sample_item_t pending_samples[$];
  seg_event_t   expected_events[$];
  sample_item_t cur_item;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_req       = 0;
  int unsigned hold_ack       = 0;
  int unsigned stall_left     = 0;
  int unsigned mismatch_cnt   = 0;
  logic [31:0] stim_ms        = 32'd1000;

  // Mirror of the tracker state.
  logic [15:0] gap_cfg      = 16'd1500;
  logic [15:0] act_cfg      = 16'd250;
  logic [31:0] abs_acc      = '0;
  logic [31:0] frame_cnt    = '0;
  logic        seg_open     = 1'b0;
  logic [31:0] seg_start_ms = '0;
  logic [31:0] last_end_ms  = '0;
  logic [7:0]  burst_cnt    = '0;
  logic [31:0] lvl_total    = '0;
  logic [9:0]  lvl_peak     = '0;
  logic [31:0] seg_frames   = '0;
  logic [31:0] last_act_ms  = '0;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatch_cnt++;
  endtask

  task automatic check_field(input string name, input int unsigned got, input int unsigned want);
    if (got != want)
      report_mismatch($sformatf("%s: got %0d, expected %0d", name, got, want));
  endtask

  // Accumulates one accepted sample and, on a frame end, predicts the event it causes.
  function automatic void track_sample(input sample_item_t it);
    logic [31:0] mag;
    logic [31:0] mean;
    logic [31:0] dur;
    logic [31:0] avg;
    logic [9:0]  lvl;
    seg_event_t  ev;
    mag = it.sample[15] ? 32'h10000 - {16'h0, it.sample} : {16'h0, it.sample};
    if (frame_cnt < FRAME_CAP) begin
      abs_acc   += mag;
      frame_cnt += 1;
    end
    if (!it.last)
      return;
    mean      = abs_acc / frame_cnt;
    lvl       = 10'((64'(mean) * LEVEL_FULL) / SAMPLE_FULL);
    abs_acc   = '0;
    frame_cnt = '0;
    ev.kind   = EV_START;
    ev.level  = lvl;
    ev.dur    = '0;
    ev.peak   = '0;
    ev.bursts = '0;
    if (it.vad && !seg_open) begin
      seg_open     = 1'b1;
      seg_start_ms = it.now_ms;
      // A zero end time means no segment has ended yet.
      if (last_end_ms != 0 && (it.now_ms - last_end_ms) <= {16'h0, gap_cfg}) begin
        if (burst_cnt != 8'hFF)
          burst_cnt += 1;
      end else begin
        burst_cnt = 8'd1;
      end
      lvl_total   = {22'h0, lvl};
      lvl_peak    = lvl;
      seg_frames  = 32'd1;
      last_act_ms = it.now_ms;
      expected_events.push_back(ev);
    end else if (!it.vad && seg_open) begin
      dur         = it.now_ms - seg_start_ms;
      avg         = (seg_frames != 0) ? lvl_total / seg_frames : '0;
      seg_open    = 1'b0;
      last_end_ms = it.now_ms;
      ev.kind     = EV_END;
      ev.level    = avg[9:0];
      ev.dur      = (dur > 32'hFFFF) ? 16'hFFFF : dur[15:0];
      ev.peak     = lvl_peak;
      ev.bursts   = burst_cnt;
      expected_events.push_back(ev);
    end else if (it.vad) begin
      if (seg_frames != 32'hFFFF_FFFF && lvl_total <= 32'hFFFF_FFFF - lvl) begin
        lvl_total  += lvl;
        seg_frames += 1;
      end
      if (lvl > lvl_peak)
        lvl_peak = lvl;
      if ((it.now_ms - last_act_ms) >= {16'h0, act_cfg}) begin
        last_act_ms = it.now_ms;
        ev.kind     = EV_ACT;
        expected_events.push_back(ev);
      end
    end
  endfunction

  always @(posedge clk_i) begin : sample_driver
    sample_item_t nxt;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o)
        track_sample(cur_item);
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (pending_samples.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt             = pending_samples.pop_front();
          cur_item       <= nxt;
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= {nxt.now_ms, nxt.sample};
          s_axis_tlast_i  <= nxt.last;
          s_axis_tuser_i  <= nxt.vad;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : event_monitor
    seg_event_t want;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (expected_events.size() == 0) begin
          report_mismatch($sformatf("event of kind %0d with none expected", m_axis_tuser_o));
        end else begin
          want = expected_events.pop_front();
          check_field("event_kind", m_axis_tuser_o, want.kind);
          check_field("level_value", m_axis_tdata_o[9:0], want.level);
          check_field("duration_ms", m_axis_tdata_o[25:10], want.dur);
          check_field("peak_level", m_axis_tdata_o[35:26], want.peak);
          check_field("burst_count", m_axis_tdata_o[43:36], want.bursts);
        end
      end
      // A long hold-off lets the result register fill and back up the input.
      if (hold_req != hold_ack) begin
        hold_ack        <= hold_req;
        stall_left      <= HOLD_CYCLES;
        m_axis_tready_i <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left      <= stall_left - 1;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  task automatic push_item(input logic [15:0] sample, input logic last, input logic vad,
                           input logic [31:0] now_ms);
    sample_item_t it;
    it.sample = sample;
    it.last   = last;
    it.vad    = vad;
    it.now_ms = now_ms;
    pending_samples.push_back(it);
  endtask

  // Samples before the last carry random flag and time, which the block ignores.
  task automatic push_frame(input int unsigned len, input logic vad, input logic [31:0] now_ms);
    int unsigned r;
    logic [15:0] s;
    for (int unsigned i = 1; i <= len; i++) begin
      r = $urandom_range(0, 9);
      if (r == 0)
        s = 16'h7FFF;
      else if (r == 1)
        s = 16'h8000;
      else if (r == 2)
        s = 16'($urandom_range(0, 40));
      else if (r == 3)
        s = -16'($urandom_range(0, 40));
      else
        s = 16'($urandom);
      if (i == len)
        push_item(s, 1'b1, vad, now_ms);
      else
        push_item(s, 1'b0, 1'($urandom), $urandom);
    end
  endtask

  // Mostly well-formed speech: runs of silent frames, then runs of active frames.
  task automatic push_random(input int unsigned n_items);
    int unsigned pushed;
    int unsigned run_left;
    int unsigned len;
    int unsigned r;
    logic        vad_run;
    logic        vad;
    pushed   = 0;
    run_left = 0;
    vad_run  = 1'b1;
    while (pushed < n_items) begin
      if (run_left == 0) begin
        vad_run  = !vad_run;
        run_left = vad_run ? $urandom_range(1, 8) : $urandom_range(1, 3);
      end
      run_left--;
      vad = ($urandom_range(0, 9) == 0) ? !vad_run : vad_run;
      r = $urandom_range(0, 99);
      if (r < 70)
        len = $urandom_range(1, 4);
      else if (r < 95)
        len = $urandom_range(5, 20);
      else
        len = $urandom_range(21, 80);
      r = $urandom_range(0, 99);
      if (r < 80)
        stim_ms += $urandom_range(0, 400);
      else if (r < 93)
        stim_ms += $urandom_range(400, 3000);
      else if (r < 98)
        stim_ms += $urandom_range(3000, 80000);
      else
        stim_ms = $urandom;
      push_frame(len, vad, stim_ms);
      pushed += len;
    end
  endtask

  task automatic wait_idle();
    while (pending_samples.size() != 0 || s_axis_tvalid_i || expected_events.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_BURST_GAP: gap_cfg = val;
      CFG_ACT_INT:   act_cfg = val;
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [CFG_W-1:0] gap, input logic [CFG_W-1:0] act,
                              input logic poke_unmapped);
    if (poke_unmapped) begin
      write_reg(CFG_UNMAPPED_LO, 16'hFFFF);
      write_reg(CFG_UNMAPPED_HI, 16'h5A5A);
    end
    write_reg(CFG_BURST_GAP, gap);
    write_reg(CFG_ACT_INT, act);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: burst gap 1500, activity interval 250.
    push_item(16'h0000, 1'b1, 1'b0, 32'd10);
    push_item(16'h7FFF, 1'b1, 1'b1, 32'd20);
    push_item(16'h8000, 1'b0, 1'b0, 32'hFFFF_FFFF);
    push_item(16'h8000, 1'b1, 1'b1, 32'd270);         // activity exactly one interval later
    push_item(16'd100,  1'b1, 1'b1, 32'd300);         // too soon for activity
    push_item(16'd1,    1'b1, 1'b0, 32'd70000);       // duration saturates
    push_item(16'h8001, 1'b1, 1'b1, 32'd71500);       // gap equal to the limit continues the burst
    push_item(16'd3,    1'b1, 1'b0, 32'd71600);
    push_item(16'h0400, 1'b1, 1'b1, 32'd73101);       // one past the limit restarts it
    push_item(16'hFFFF, 1'b1, 1'b0, 32'd0);           // ends at time zero, looks like never ended
    push_item(16'd50,   1'b1, 1'b1, 32'd5);
    push_item(16'd50,   1'b1, 1'b0, 32'hFFFF_FFFF);
    push_item(16'd50,   1'b1, 1'b1, 32'd100);         // gap wraps around zero
    push_item(16'hFFFB, 1'b0, 1'b1, 32'd0);
    push_item(16'd7,    1'b0, 1'b0, 32'hAAAA_5555);
    push_item(16'd3,    1'b1, 1'b1, 32'd400);
    push_item(16'd0,    1'b1, 1'b1, 32'd649);
    push_item(16'd0,    1'b1, 1'b0, 32'd700);
    push_item(16'd0,    1'b1, 1'b0, 32'd900);
    wait_idle();

    // Lowest settings, no idling, and a full-scale frame that reaches the top level.
    program_regs(16'h0000, 16'h0000, 1'b1);
    stim_ms = $urandom;
    for (int unsigned i = 0; i < 4; i++)
      push_item(16'h8000, i == 3, 1'b1, stim_ms);
    push_random(100);
    wait_idle();

    program_regs(16'hFFFF, 16'hFFFF, 1'b0);
    send_idle_pct = 83;
    push_random(100);
    wait_idle();

    program_regs(16'($urandom_range(0, 3000)), 16'($urandom_range(0, 600)), 1'b0);
    send_idle_pct  = 0;
    recv_stall_pct = 83;
    push_random(100);
    wait_idle();

    program_regs(16'd1500, 16'd100, 1'b0);
    send_idle_pct  = 37;
    recv_stall_pct = 37;
    push_random(100);
    wait_idle();

    // Every active frame raises an event while the receiver holds off.
    program_regs(16'd1500, 16'd0, 1'b0);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req++;
    for (int unsigned i = 0; i < 42; i++) begin
      stim_ms += 1;
      push_frame(1, i != 41, stim_ms);
    end
    wait_idle();

    if (mismatch_cnt == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #(TIME_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
